// ===== rtl/spt_pkg.sv =====
`default_nettype none

package spt_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;

  // Opcode boundaries of the push encodings.
  localparam logic [ByteW-1:0] OpZero      = 8'h00;
  localparam logic [ByteW-1:0] OpPushMax   = 8'h4b;
  localparam logic [ByteW-1:0] OpPushData1 = 8'h4c;
  localparam logic [ByteW-1:0] OpPushData2 = 8'h4d;
  localparam logic [ByteW-1:0] OpPushData4 = 8'h4e;
  localparam logic [ByteW-1:0] OpInvalid   = 8'hff;

  typedef enum logic [1:0] {
    KIND_OPCODE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_BAD_OP    = 2'd1,
    FAULT_TRUNC_LEN = 2'd2,
    FAULT_TRUNC_DAT = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  value;
    logic [LenW-1:0]   length;
    logic              done;
    fault_e            fault;
  } token_t;

endpackage

`default_nettype wire

// ===== rtl/spt_core.sv =====
`default_nettype none

module spt_core
  import spt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             last_i,
  output logic                  res_valid_o,
  output token_t                res_o
);

  phase_e          phase_q, phase_d;
  logic [2:0]      len_left_q, len_left_d;
  logic [1:0]      len_shift_q, len_shift_d;
  logic [LenW-1:0] len_accum_q, len_accum_d;
  logic [LenW-1:0] data_left_q, data_left_d;
  logic            failed_q, failed_d;

  logic [LenW-1:0] accum_new;
  logic [2:0]      left_new;
  logic [LenW-1:0] data_new;

  assign accum_new = len_accum_q | ({{(LenW-ByteW){1'b0}}, byte_i} << {len_shift_q, 3'b000});
  assign left_new  = len_left_q - 3'd1;
  assign data_new  = data_left_q - {{(LenW-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    len_shift_d = len_shift_q;
    len_accum_d = len_accum_q;
    data_left_d = data_left_q;
    failed_d    = failed_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_NONE, value: '0, length: '0, done: 1'b0, fault: FAULT_NONE};

    if (step_i) begin
      if (!failed_q) begin
        unique case (phase_q)
          PH_LENGTH: begin
            len_accum_d = accum_new;
            len_shift_d = len_shift_q + 2'd1;
            len_left_d  = left_new;
            if (left_new == 3'd0) begin
              res_valid_o = 1'b1;
              if (accum_new == '0) begin
                res_o.kind = KIND_HEADER;
                res_o.done = 1'b1;
                phase_d    = PH_OPCODE;
              end else if (last_i) begin
                res_o.fault = FAULT_TRUNC_DAT;
                failed_d    = 1'b1;
              end else begin
                res_o.kind   = KIND_HEADER;
                res_o.length = accum_new;
                data_left_d  = accum_new;
                phase_d      = PH_DATA;
              end
            end else if (last_i) begin
              res_valid_o = 1'b1;
              res_o.fault = FAULT_TRUNC_LEN;
              failed_d    = 1'b1;
            end
          end
          PH_DATA: begin
            data_left_d = data_new;
            res_valid_o = 1'b1;
            if (data_new == '0) begin
              res_o.kind  = KIND_DATA;
              res_o.value = byte_i;
              res_o.done  = 1'b1;
              phase_d     = PH_OPCODE;
            end else if (last_i) begin
              res_o.fault = FAULT_TRUNC_DAT;
              failed_d    = 1'b1;
            end else begin
              res_o.kind  = KIND_DATA;
              res_o.value = byte_i;
            end
          end
          default: begin
            // The unused phase code behaves as the opcode phase.
            if (byte_i != OpZero && byte_i <= OpPushMax) begin
              res_valid_o = 1'b1;
              if (last_i) begin
                res_o.fault = FAULT_TRUNC_DAT;
                failed_d    = 1'b1;
              end else begin
                res_o.kind   = KIND_HEADER;
                res_o.length = {{(LenW-ByteW){1'b0}}, byte_i};
                data_left_d  = {{(LenW-ByteW){1'b0}}, byte_i};
                phase_d      = PH_DATA;
              end
            end else if (byte_i >= OpPushData1 && byte_i <= OpPushData4) begin
              if (byte_i == OpPushData1) begin
                len_left_d = 3'd1;
              end else if (byte_i == OpPushData2) begin
                len_left_d = 3'd2;
              end else begin
                len_left_d = 3'd4;
              end
              len_shift_d = '0;
              len_accum_d = '0;
              phase_d     = PH_LENGTH;
              if (last_i) begin
                res_valid_o = 1'b1;
                res_o.fault = FAULT_TRUNC_LEN;
                failed_d    = 1'b1;
              end
            end else if (byte_i == OpInvalid) begin
              res_valid_o = 1'b1;
              res_o.fault = FAULT_BAD_OP;
              failed_d    = 1'b1;
            end else begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_OPCODE;
              res_o.value = byte_i;
              res_o.done  = 1'b1;
              phase_d     = PH_OPCODE;
            end
          end
        endcase
      end

      // Every script starts from a clean state, whatever happened before.
      if (last_i) begin
        phase_d     = PH_OPCODE;
        len_left_d  = '0;
        len_shift_d = '0;
        len_accum_d = '0;
        data_left_d = '0;
        failed_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      len_left_q  <= '0;
      len_shift_q <= '0;
      len_accum_q <= '0;
      data_left_q <= '0;
      failed_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      len_shift_q <= len_shift_d;
      len_accum_q <= len_accum_d;
      data_left_q <= data_left_d;
      failed_q    <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/script_push_tokenizer.sv =====
`default_nettype none

// Channel  Dir  Handshake                Payload
// s_axis   in   s_axis_tvalid/tready_o   tdata: script_byte; tlast: script_end
// m_axis   out  m_axis_tvalid/tready_i   tdata: token_value, push_length;
//                                        tuser: token_kind, fault;
//                                        tlast: instruction_done
//
// One script byte is taken per cycle while s_axis_tready_o is high. A byte is held
// in the input register, decoded and applied to the tokenizer state once the output
// register can take a result, and its token, if any, is registered in that same cycle.
// Reset clears the tokenizer state and both register stages.
// A stalled output register holds the pipeline; the input side keeps going as
// long as the input register is empty or drains in the same cycle.

module script_push_tokenizer
  import spt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] script_byte
  input  wire logic        s_axis_tlast_i,   // script_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [7:0] token_value, [39:8] push_length
  output logic [3:0]       m_axis_tuser_o,   // [1:0] token_kind, [3:2] fault
  output logic             m_axis_tlast_o    // instruction_done
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q, out_valid_d;
  token_t           out_tok_q;
  logic             advance;
  logic             step;
  logic             res_valid;
  token_t           res;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  spt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_tok_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_tok_q.length, out_tok_q.value};
  assign m_axis_tuser_o  = {out_tok_q.fault, out_tok_q.kind};
  assign m_axis_tlast_o  = out_tok_q.done;

endmodule

`default_nettype wire
